// ===== design/bohp_pkg.sv =====
`timescale 1ns / 1ps
package bohp_pkg;

    localparam int ADDR_BITS_DEF  = 8;
    localparam int HIST_BITS_DEF  = 8;
    localparam int COUNT_BITS_DEF = 32;

    localparam int BRANCH_ADDR_W = 48;
    localparam int READ_HIST_W   = 8;
    localparam int OUT_COUNT_W   = 32;
    localparam int OUT_HIST_W    = 8;

    typedef enum logic [1:0] {
        CMD_EVENT       = 2'd0,
        CMD_READ_GLOBAL = 2'd1,
        CMD_READ_LOCAL  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ALIAS,
        ST_RD_LOCAL,
        ST_UPDATE
    } state_t;

endpackage

// ===== design/branch_outcome_history_profiler.sv =====
`timescale 1ns / 1ps
// Branch outcome profiler: keeps taken/not-taken counts per (address alias, global history)
// and per (alias, local history), plus transition statistics per (alias, global history)
// and per alias, all in single-port-write synchronous memories. An accepted transfer passes
// through ST_RD_ALIAS, ST_RD_LOCAL and ST_UPDATE to the result register, in an order set
// by the dependent memory reads: the local history of the alias is read first and then
// selects the local outcome entry. A new transfer is accepted only in ST_IDLE, after the
// last one has left ST_UPDATE; a result held by out_stall keeps ST_UPDATE until the output
// register frees. The next transfer is accepted while a result still waits in the output
// register. After reset a clearing pass zeroes all memories; no transfer is accepted until
// it ends. Count outputs are the low 32 bits of the saturating counters.
module branch_outcome_history_profiler #(
    parameter int ADDR_BITS  = bohp_pkg::ADDR_BITS_DEF,
    parameter int HIST_BITS  = bohp_pkg::HIST_BITS_DEF,
    parameter int COUNT_BITS = bohp_pkg::COUNT_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           cmd,
    input  logic [bohp_pkg::BRANCH_ADDR_W-1:0]   branch_addr,
    input  logic                                 taken,
    input  logic [bohp_pkg::READ_HIST_W-1:0]     read_history,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bohp_pkg::OUT_COUNT_W-1:0]     taken_count,
    output logic [bohp_pkg::OUT_COUNT_W-1:0]     not_taken_count,
    output logic [bohp_pkg::OUT_COUNT_W-1:0]     transition_count,
    output logic [bohp_pkg::OUT_COUNT_W-1:0]     execution_count,
    output logic [bohp_pkg::OUT_HIST_W-1:0]      history_now
);

    import bohp_pkg::*;

    localparam int ENTRY_BITS = ADDR_BITS + HIST_BITS;

    typedef struct packed {
        logic                  prev;
        logic [COUNT_BITS-1:0] changes;
        logic [COUNT_BITS-1:0] execs;
    } trans_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] taken_n;
        logic [COUNT_BITS-1:0] not_taken_n;
    } outc_t;

    typedef struct packed {
        outc_t  outc;
        trans_t trans;
    } grow_t;

    typedef struct packed {
        logic [HIST_BITS-1:0] lhist;
        trans_t               trans;
    } arow_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic trans_t upd_trans(input trans_t t, input logic o);
        trans_t r;
        r = t;
        if ((t.execs != '0) && (t.prev != o))
        begin
            r.changes = sat_inc(t.changes);
        end
        r.execs = sat_inc(t.execs);
        r.prev  = o;
        return r;
    endfunction

    function automatic outc_t upd_outc(input outc_t c, input logic o);
        outc_t r;
        r = c;
        if (o)
        begin
            r.taken_n = sat_inc(c.taken_n);
        end
        else
        begin
            r.not_taken_n = sat_inc(c.not_taken_n);
        end
        return r;
    endfunction

    state_t                 state_reg, state_next;
    logic [ENTRY_BITS-1:0]  clr_reg, clr_next;
    logic [HIST_BITS-1:0]   ghist_reg, ghist_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [ADDR_BITS-1:0]   alias_reg, alias_next;
    logic [HIST_BITS-1:0]   rhist_reg, rhist_next;
    logic                   taken_reg, taken_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_COUNT_W-1:0] taken_count_reg, taken_count_next;
    logic [OUT_COUNT_W-1:0] not_taken_count_reg, not_taken_count_next;
    logic [OUT_COUNT_W-1:0] transition_count_reg, transition_count_next;
    logic [OUT_COUNT_W-1:0] execution_count_reg, execution_count_next;
    logic [OUT_HIST_W-1:0]  history_now_reg, history_now_next;

    logic clearing;
    logic in_xfer;
    logic out_free;
    logic commit;
    logic is_event;
    logic upd_we;

    logic [$bits(grow_t)-1:0] g_rdata;
    logic [$bits(outc_t)-1:0] l_rdata;
    logic [$bits(arow_t)-1:0] a_rdata;
    grow_t                    g_rd, g_new;
    outc_t                    l_rd, l_new;
    arow_t                    a_rd, a_new;

    logic [ENTRY_BITS-1:0]    g_addr, l_addr;
    logic [ENTRY_BITS-1:0]    g_waddr, l_waddr;
    logic [ADDR_BITS-1:0]     a_waddr;
    logic                     g_we, l_we, a_we;
    grow_t                    g_wdata;
    outc_t                    l_wdata;
    arow_t                    a_wdata;

    assign g_rd = g_rdata;
    assign l_rd = l_rdata;
    assign a_rd = a_rdata;

    assign is_event = (cmd_reg == CMD_EVENT);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_xfer  = in_valid && !in_stall;

    // addresses stay stable from the first read cycle until commit
    assign g_addr = {alias_reg, (is_event ? ghist_reg : rhist_reg)};
    assign l_addr = {alias_reg, (is_event ? a_rd.lhist : rhist_reg)};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == {ENTRY_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RD_ALIAS;
                end
            end
            ST_RD_ALIAS:
            begin
                state_next = ST_RD_LOCAL;
            end
            ST_RD_LOCAL:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall = 1'b1;
        clearing = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_UPDATE:
            begin
                commit = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // read-modify-write datapath
    always_comb
    begin
        g_new.outc  = upd_outc(g_rd.outc, taken_reg);
        g_new.trans = upd_trans(g_rd.trans, taken_reg);
        l_new       = upd_outc(l_rd, taken_reg);
        a_new.trans = upd_trans(a_rd.trans, taken_reg);
        a_new.lhist = HIST_BITS'({a_rd.lhist, taken_reg});
    end

    assign upd_we  = commit && is_event;
    assign g_we    = clearing || upd_we;
    assign l_we    = clearing || upd_we;
    assign a_we    = clearing || upd_we;
    assign g_waddr = clearing ? clr_reg : g_addr;
    assign l_waddr = clearing ? clr_reg : l_addr;
    assign a_waddr = clearing ? clr_reg[ADDR_BITS-1:0] : alias_reg;
    assign g_wdata = clearing ? '0 : g_new;
    assign l_wdata = clearing ? '0 : l_new;
    assign a_wdata = clearing ? '0 : a_new;

    bohp_ram #(
        .ADDR_W (ENTRY_BITS),
        .DATA_W ($bits(grow_t))
    ) u_global_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_addr),
        .rdata (g_rdata)
    );

    bohp_ram #(
        .ADDR_W (ENTRY_BITS),
        .DATA_W ($bits(outc_t))
    ) u_local_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_addr),
        .rdata (l_rdata)
    );

    bohp_ram #(
        .ADDR_W (ADDR_BITS),
        .DATA_W ($bits(arow_t))
    ) u_alias_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (alias_reg),
        .rdata (a_rdata)
    );

    // register next values
    always_comb
    begin
        clr_next   = clearing ? clr_reg + 1'b1 : clr_reg;
        ghist_next = upd_we ? HIST_BITS'({ghist_reg, taken_reg}) : ghist_reg;

        cmd_next   = cmd_reg;
        alias_next = alias_reg;
        rhist_next = rhist_reg;
        taken_next = taken_reg;
        if (in_xfer)
        begin
            cmd_next   = cmd_t'(cmd);
            alias_next = branch_addr[ADDR_BITS-1:0];
            rhist_next = HIST_BITS'(read_history);
            taken_next = taken;
        end

        out_valid_next        = commit || (out_valid_reg && out_stall);
        taken_count_next      = taken_count_reg;
        not_taken_count_next  = not_taken_count_reg;
        transition_count_next = transition_count_reg;
        execution_count_next  = execution_count_reg;
        history_now_next      = history_now_reg;
        if (commit)
        begin
            case (cmd_reg)
                CMD_EVENT:
                begin
                    taken_count_next      = OUT_COUNT_W'(g_new.outc.taken_n);
                    not_taken_count_next  = OUT_COUNT_W'(g_new.outc.not_taken_n);
                    transition_count_next = OUT_COUNT_W'(g_new.trans.changes);
                    execution_count_next  = OUT_COUNT_W'(g_new.trans.execs);
                    history_now_next      = OUT_HIST_W'(ghist_next);
                end
                CMD_READ_GLOBAL:
                begin
                    taken_count_next      = OUT_COUNT_W'(g_rd.outc.taken_n);
                    not_taken_count_next  = OUT_COUNT_W'(g_rd.outc.not_taken_n);
                    transition_count_next = OUT_COUNT_W'(g_rd.trans.changes);
                    execution_count_next  = OUT_COUNT_W'(g_rd.trans.execs);
                    history_now_next      = OUT_HIST_W'(a_rd.lhist);
                end
                CMD_READ_LOCAL:
                begin
                    taken_count_next      = OUT_COUNT_W'(l_rd.taken_n);
                    not_taken_count_next  = OUT_COUNT_W'(l_rd.not_taken_n);
                    transition_count_next = OUT_COUNT_W'(a_rd.trans.changes);
                    execution_count_next  = OUT_COUNT_W'(a_rd.trans.execs);
                    history_now_next      = OUT_HIST_W'(a_rd.lhist);
                end
                default:
                begin
                    taken_count_next      = '0;
                    not_taken_count_next  = '0;
                    transition_count_next = '0;
                    execution_count_next  = '0;
                    history_now_next      = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            ghist_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ghist_reg     <= ghist_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg              <= cmd_next;
        alias_reg            <= alias_next;
        rhist_reg            <= rhist_next;
        taken_reg            <= taken_next;
        taken_count_reg      <= taken_count_next;
        not_taken_count_reg  <= not_taken_count_next;
        transition_count_reg <= transition_count_next;
        execution_count_reg  <= execution_count_next;
        history_now_reg      <= history_now_next;
    end

    assign out_valid        = out_valid_reg;
    assign taken_count      = taken_count_reg;
    assign not_taken_count  = not_taken_count_reg;
    assign transition_count = transition_count_reg;
    assign execution_count  = execution_count_reg;
    assign history_now      = history_now_reg;

endmodule

// ===== design/bohp_ram.sv =====
`timescale 1ns / 1ps
module bohp_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 64
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
